[design/greedy_weighted_edge_matching_defines.svh]
// Assertion macros shared by the matching block.
`ifndef GREEDY_WEIGHTED_EDGE_MATCHING_DEFINES_SVH
`define GREEDY_WEIGHTED_EDGE_MATCHING_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define GWM_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GWM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

[design/gwm_pkg.sv]
// Types, constants and register codes for the greedy edge matching block.
package gwm_pkg;

    localparam int ID_W        = 16;
    localparam int WEIGHT_W    = 32;
    localparam int PART_W      = 8;
    localparam int MAXW_W      = 33;
    localparam int COUNT_W     = 17;
    localparam int WEIGHT_BITS = 32;
    localparam int PART_BITS   = 8;
    localparam int MAX_NODES_DEFAULT = 65536;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [PART_W-1:0]   PART_MASK   = PART_W'((64'd1 << PART_BITS) - 64'd1);
    localparam logic [MAXW_W-1:0]   MAXW_RESET  = 33'h1_FFFF_FFFE;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WEIGHT   = 2'd0,
        CFG_RESPECT_PART = 2'd1,
        CFG_CHECK_SECOND = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [MAXW_W-1:0] max_weight;
        logic              respect_part;
        logic              check_second;
    } cfg_t;

    typedef struct packed {
        logic                mode;
        logic [ID_W-1:0]     node_id;
        logic [WEIGHT_W-1:0] node_weight;
        logic [PART_W-1:0]   node_part;
        logic [PART_W-1:0]   node_part_second;
        logic                has_edge;
        logic [ID_W-1:0]     target_id;
        logic [WEIGHT_W-1:0] target_weight;
        logic [PART_W-1:0]   target_part;
        logic [PART_W-1:0]   target_part_second;
        logic                last_edge;
    } cand_t;

    typedef struct packed {
        logic            emit;
        logic [ID_W-1:0] partner;
        logic            resolved;
        logic            clear;
    } decision_t;

endpackage

[design/gwm_cand_if.sv]
// Candidate edge channel.
interface gwm_cand_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] node_id;
    logic [31:0] node_weight;
    logic [7:0]  node_part;
    logic [7:0]  node_part_second;
    logic        has_edge;
    logic [15:0] target_id;
    logic [31:0] target_weight;
    logic [7:0]  target_part;
    logic [7:0]  target_part_second;
    logic        last_edge;

    modport source (
        output valid, mode, node_id, node_weight, node_part, node_part_second,
               has_edge, target_id, target_weight, target_part, target_part_second,
               last_edge,
        input  ready
    );

    modport sink (
        input  valid, mode, node_id, node_weight, node_part, node_part_second,
               has_edge, target_id, target_weight, target_part, target_part_second,
               last_edge,
        output ready
    );
endinterface

[design/gwm_pair_if.sv]
// Matched pair channel.
interface gwm_pair_if;
    logic        valid;
    logic        ready;
    logic [15:0] pair_node;
    logic [15:0] partner_node;
    logic [15:0] coarse_id;

    modport source (
        output valid, pair_node, partner_node, coarse_id,
        input  ready
    );

    modport sink (
        input  valid, pair_node, partner_node, coarse_id,
        output ready
    );
endinterface

[design/gwm_flags.sv]
// Matched-flag bitmap: one write port, two registered read ports, clearing sweep.
module gwm_flags
    import gwm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear_start,
    output logic                         clear_busy,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr_a,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr_b,
    output logic                         rd_a,
    output logic                         rd_b
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

    logic          mem [MAX_NODES];
    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          rd_a_reg;
    logic          rd_b_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
            begin
                busy_next    = 1'b0;
                clr_cnt_next = '0;
            end
        end
        else if (clear_start)
        begin
            busy_next    = 1'b1;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= 1'b1;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign clear_busy = busy_reg;
    assign rd_a       = rd_a_reg;
    assign rd_b       = rd_b_reg;

endmodule

[design/gwm_decide.sv]
// Match decision for one registered candidate edge.
module gwm_decide
    import gwm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
)
(
    input  cand_t           item,
    input  cfg_t            cfg,
    input  logic            resolved,
    input  logic            rd_node,
    input  logic            rd_target,
    input  logic            fwd_valid,
    input  logic [ID_W-1:0] fwd_id,
    output decision_t       dec
);

    logic              node_in;
    logic              target_in;
    logic              node_flag;
    logic              target_flag;
    logic [MAXW_W-1:0] sum;
    logic              weight_ok;
    logic              part_ok;
    logic              ends;
    logic              active;
    logic              found;

    always_comb
    begin
        node_in   = 32'(item.node_id) < 32'(MAX_NODES);
        target_in = 32'(item.target_id) < 32'(MAX_NODES);

        // partner write of the previous pair lands after this item's read
        node_flag   = !node_in || rd_node ||
                      (fwd_valid && (fwd_id == item.node_id));
        target_flag = !target_in || rd_target ||
                      (fwd_valid && (fwd_id == item.target_id));

        sum       = {1'b0, item.node_weight & WEIGHT_MASK} +
                    {1'b0, item.target_weight & WEIGHT_MASK};
        weight_ok = sum <= cfg.max_weight;
        part_ok   = !cfg.respect_part ||
                    (((item.node_part & PART_MASK) == (item.target_part & PART_MASK)) &&
                     (!cfg.check_second ||
                      ((item.node_part_second & PART_MASK) ==
                       (item.target_part_second & PART_MASK))));

        ends   = item.last_edge || !item.has_edge;
        active = !item.mode && !resolved && node_in;
        found  = item.has_edge && (item.target_id != item.node_id) && !target_flag &&
                 weight_ok && part_ok;

        dec.clear   = item.mode;
        dec.emit    = active && !node_flag && (found || ends);
        dec.partner = found ? item.target_id : item.node_id;
        if (item.mode || ends)
        begin
            dec.resolved = 1'b0;
        end
        else
        begin
            dec.resolved = resolved || (active && (node_flag || dec.emit));
        end
    end

endmodule

[design/greedy_weighted_edge_matching.sv]
// Greedy weighted edge matching: top level with input, decision and result registers.
//
// Takes a new candidate edge item only once the last one has been decided; a pair is
// decided from the input register and shown from the result register. The matched-flag
// bitmap has a single write port: a pair marks its node in the decision cycle and its
// partner in the following cycle. The bitmap is swept clear one entry per cycle after
// reset and after every new-pass item; no items are taken during the sweep, while
// configuration writes are. The result register holds a pair until it is taken and the
// next item is accepted meanwhile; only the following decision waits on it.
`include "greedy_weighted_edge_matching_defines.svh"

module greedy_weighted_edge_matching
    import gwm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    gwm_cand_if.sink               cand,
    gwm_pair_if.source             pair,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MAXW_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_NODES);

    cfg_t                 cfg_reg;
    cand_t                item_reg;
    logic                 valid_reg;
    logic                 resolved_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 pend_reg;
    logic [ID_W-1:0]      pend_id_reg;
    logic                 fwd_valid_reg;
    logic [ID_W-1:0]      fwd_id_reg;
    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_node_reg;
    logic [ID_W-1:0]      out_partner_reg;
    logic [ID_W-1:0]      out_coarse_reg;

    cand_t                cand_item;
    decision_t            dec;
    logic                 accept;
    logic                 decide_go;
    logic                 node_wr;
    logic                 clear_busy;
    logic                 rd_node;
    logic                 rd_target;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;

    assign cand_item = '{
        mode:               cand.mode,
        node_id:            cand.node_id,
        node_weight:        cand.node_weight,
        node_part:          cand.node_part,
        node_part_second:   cand.node_part_second,
        has_edge:           cand.has_edge,
        target_id:          cand.target_id,
        target_weight:      cand.target_weight,
        target_part:        cand.target_part,
        target_part_second: cand.target_part_second,
        last_edge:          cand.last_edge
    };

    assign cand.ready = !clear_busy && !valid_reg;
    assign accept     = cand.valid && cand.ready;
    assign decide_go  = valid_reg && (!out_valid_reg || pair.ready);
    assign node_wr    = decide_go && dec.emit;

    assign wr_en   = node_wr || pend_reg;
    assign wr_addr = node_wr ? AW'(item_reg.node_id) : AW'(pend_id_reg);

    gwm_flags #(
        .MAX_NODES (MAX_NODES)
    ) u_flags (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (decide_go && dec.clear),
        .clear_busy  (clear_busy),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (accept),
        .rd_addr_a   (AW'(cand.node_id)),
        .rd_addr_b   (AW'(cand.target_id)),
        .rd_a        (rd_node),
        .rd_b        (rd_target)
    );

    gwm_decide #(
        .MAX_NODES (MAX_NODES)
    ) u_decide (
        .item      (item_reg),
        .cfg       (cfg_reg),
        .resolved  (resolved_reg),
        .rd_node   (rd_node),
        .rd_target (rd_target),
        .fwd_valid (fwd_valid_reg),
        .fwd_id    (fwd_id_reg),
        .dec       (dec)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_weight   <= MAXW_RESET;
            cfg_reg.respect_part <= 1'b0;
            cfg_reg.check_second <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_WEIGHT:   cfg_reg.max_weight   <= cfg_data;
                CFG_RESPECT_PART: cfg_reg.respect_part <= cfg_data[0];
                CFG_CHECK_SECOND: cfg_reg.check_second <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            resolved_reg  <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg     <= 1'b1;
                fwd_valid_reg <= pend_reg;
            end
            else if (decide_go)
            begin
                valid_reg <= 1'b0;
            end

            pend_reg <= node_wr;

            if (decide_go)
            begin
                resolved_reg <= dec.resolved;
                if (dec.clear)
                begin
                    count_reg <= '0;
                end
                else if (dec.emit)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (node_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pair.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= cand_item;
            fwd_id_reg <= pend_id_reg;
        end
        if (node_wr)
        begin
            pend_id_reg     <= dec.partner;
            out_node_reg    <= item_reg.node_id;
            out_partner_reg <= dec.partner;
            out_coarse_reg  <= count_reg[ID_W-1:0];
        end
    end

    assign pair.valid        = out_valid_reg;
    assign pair.pair_node    = out_node_reg;
    assign pair.partner_node = out_partner_reg;
    assign pair.coarse_id    = out_coarse_reg;

    `GWM_ASSERT_IMP(a_no_take_in_sweep, clk, rst_n, clear_busy, !cand.ready, "item taken during clearing sweep")
    `GWM_ASSERT_IMP(a_one_write, clk, rst_n, node_wr, !pend_reg, "node and partner flag writes collide")
    `GWM_ASSERT_NEXT(a_count_step, clk, rst_n, node_wr, count_reg == $past(count_reg) + 1'b1, "coarse count not advanced by one pair")
    `GWM_ASSERT_NEXT(a_partner_marked, clk, rst_n, node_wr, pend_reg && out_valid_reg, "pair shown without partner flag write")

endmodule
